>>> rtl/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
package sbsm_pkg;

  localparam logic [1:0] ModeRegWrite = 2'd0;
  localparam logic [1:0] ModeProgRead = 2'd1;
  localparam logic [1:0] ModePatRead  = 2'd2;
  localparam logic [1:0] ModePatWrite = 2'd3;

  localparam logic [1:0] TargetNone   = 2'd0;
  localparam logic [1:0] TargetPrgRom = 2'd1;
  localparam logic [1:0] TargetChrRom = 2'd2;
  localparam logic [1:0] TargetChrRam = 2'd3;

  localparam logic [1:0] MirrorHorizontal = 2'd3;
  localparam logic [1:0] PrgModeFixLast   = 2'd3;

  localparam logic [15:0] CtrlAddrMax    = 16'h9FFF;
  localparam logic [15:0] ChrLowAddrMax  = 16'hBFFF;
  localparam logic [15:0] ChrHighAddrMax = 16'hDFFF;
  localparam logic [15:0] PrgUpperBase   = 16'hC000;
  localparam logic [12:0] ChrUpperBase   = 13'h1000;

  localparam logic [2:0] LoadBits = 3'd5;

  localparam logic [0:0] CfgPrgBankCount = 1'd0;
  localparam logic [0:0] CfgChrIsRam     = 1'd1;

  typedef struct packed {
    logic [1:0] mirror_mode;
    logic [1:0] prg_mode;
    logic       chr_mode;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank;
  } bank_state_t;

  typedef struct packed {
    logic [17:0] phys_addr;
    logic [1:0]  target;
    logic        mem_write;
  } xlate_res_t;

endpackage

>>> rtl/sbsm_loader.sv
// Serial load register and bank/control registers.
module sbsm_loader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [15:0]         bus_address_i,
  input  logic [7:0]          write_data_i,
  output sbsm_pkg::bank_state_t state_o,
  output logic [1:0]          mirror_next_o
);

  logic [4:0] load_shift_q, load_shift_d;
  logic [2:0] load_count_q, load_count_d;
  sbsm_pkg::bank_state_t state_q, state_d;
  logic [4:0] shift_nxt;
  logic [2:0] count_inc;

  assign shift_nxt = {write_data_i[0], load_shift_q[4:1]};
  assign count_inc = load_count_q + 3'd1;

  always_comb begin
    load_shift_d = load_shift_q;
    load_count_d = load_count_q;
    state_d      = state_q;
    if (wr_en_i) begin
      if (write_data_i[7]) begin
        load_shift_d     = '0;
        load_count_d     = '0;
        state_d.prg_mode = sbsm_pkg::PrgModeFixLast;
      end else if (count_inc == sbsm_pkg::LoadBits) begin
        load_shift_d = '0;
        load_count_d = '0;
        if (bus_address_i <= sbsm_pkg::CtrlAddrMax) begin
          state_d.mirror_mode = shift_nxt[1:0];
          state_d.prg_mode    = shift_nxt[3:2];
          state_d.chr_mode    = shift_nxt[4];
        end else if (bus_address_i <= sbsm_pkg::ChrLowAddrMax) begin
          state_d.chr_bank_low = shift_nxt;
        end else if (bus_address_i <= sbsm_pkg::ChrHighAddrMax) begin
          state_d.chr_bank_high = shift_nxt;
        end else begin
          state_d.prg_bank = shift_nxt[3:0];
        end
      end else begin
        load_shift_d = shift_nxt;
        load_count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_shift_q          <= '0;
      load_count_q          <= '0;
      state_q.mirror_mode   <= sbsm_pkg::MirrorHorizontal;
      state_q.prg_mode      <= sbsm_pkg::PrgModeFixLast;
      state_q.chr_mode      <= 1'b0;
      state_q.chr_bank_low  <= '0;
      state_q.chr_bank_high <= '0;
      state_q.prg_bank      <= '0;
    end else begin
      load_shift_q <= load_shift_d;
      load_count_q <= load_count_d;
      state_q      <= state_d;
    end
  end

  assign state_o       = state_q;
  assign mirror_next_o = state_d.mirror_mode;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q < sbsm_pkg::LoadBits)
    else $error("load count out of range");

  a_reset_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && write_data_i[7]) |=>
      (load_count_q == 3'd0 && state_q.prg_mode == sbsm_pkg::PrgModeFixLast))
    else $error("reset write did not clear loader");

  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !write_data_i[7] && load_count_q == 3'd4) |=>
      (load_count_q == 3'd0 && load_shift_q == 5'd0))
    else $error("fifth bit did not commit");
`endif

endmodule

>>> rtl/sbsm_xlate.sv
// Address translation for program and pattern accesses.
module sbsm_xlate #(
  parameter int PRG_ADDR_BITS = 18
) (
  input  logic [1:0]            mode_i,
  input  logic [15:0]           bus_address_i,
  input  sbsm_pkg::bank_state_t state_i,
  input  logic [4:0]            prg_bank_count_i,
  input  logic                  chr_is_ram_i,
  output sbsm_pkg::xlate_res_t  res_o
);

  localparam logic [17:0] PrgMask = 18'((1 << PRG_ADDR_BITS) - 1);

  logic [3:0]  bank_mask;
  logic [3:0]  prg_sel;
  logic        prg_upper;
  logic [17:0] prg_phys;
  logic [12:0] pat_addr;
  logic        chr_upper;
  logic [4:0]  chr_sel;
  logic [17:0] chr_phys;

  always_comb begin
    if (prg_bank_count_i >= 5'd16) begin
      bank_mask = 4'hF;
    end else if (prg_bank_count_i >= 5'd8) begin
      bank_mask = 4'h7;
    end else if (prg_bank_count_i >= 5'd4) begin
      bank_mask = 4'h3;
    end else begin
      bank_mask = 4'h1;
    end
  end

  assign prg_upper = bus_address_i >= sbsm_pkg::PrgUpperBase;

  always_comb begin
    if (!state_i.prg_mode[1]) begin
      prg_sel = {state_i.prg_bank[3:1], prg_upper};
    end else if (state_i.prg_mode == sbsm_pkg::PrgModeFixLast) begin
      prg_sel = prg_upper ? bank_mask : state_i.prg_bank;
    end else begin
      prg_sel = prg_upper ? state_i.prg_bank : 4'd0;
    end
  end

  assign prg_phys = {prg_sel & bank_mask, bus_address_i[13:0]} & PrgMask;

  assign pat_addr  = bus_address_i[12:0];
  assign chr_upper = pat_addr >= sbsm_pkg::ChrUpperBase;

  always_comb begin
    if (!state_i.chr_mode) begin
      chr_sel = {state_i.chr_bank_low[4:1], chr_upper};
    end else begin
      chr_sel = chr_upper ? state_i.chr_bank_high : state_i.chr_bank_low;
    end
  end

  assign chr_phys = {1'b0, chr_sel, pat_addr[11:0]};

  always_comb begin
    res_o.phys_addr = '0;
    res_o.target    = sbsm_pkg::TargetNone;
    res_o.mem_write = 1'b0;
    case (mode_i)
      sbsm_pkg::ModeRegWrite: begin
      end
      sbsm_pkg::ModeProgRead: begin
        res_o.phys_addr = prg_phys;
        res_o.target    = sbsm_pkg::TargetPrgRom;
      end
      default: begin
        if (chr_is_ram_i) begin
          res_o.phys_addr = {5'd0, pat_addr};
          res_o.target    = sbsm_pkg::TargetChrRam;
          res_o.mem_write = (mode_i == sbsm_pkg::ModePatWrite);
        end else if (mode_i == sbsm_pkg::ModePatRead) begin
          res_o.phys_addr = chr_phys;
          res_o.target    = sbsm_pkg::TargetChrRom;
        end
      end
    endcase
  end

endmodule

>>> rtl/serial_bank_switch_mapper_top.sv
// Top level of the serial bank switch mapper: item pipeline and config registers.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser mode, tdata address/data
//   m_axis    out  m_axis_tvalid/m_axis_tready  tuser target, tdata phys/wr/mirror
//   cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled; each item passes the input register, then the result register.
// Translation and serial loader update run in the cycle between the two registers.
// A stalled output holds the result; the input register still takes one more item.
// Reset: loader empty, horizontal mirroring, PRG mode 3, 16 banks, pattern ROM.
module serial_bank_switch_mapper_top #(
  parameter int PRG_ADDR_BITS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] phys_addr, [18] mem_write, [20:19] mirroring
  output logic [1:0]  m_axis_tuser,   // [1:0] target
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic        s0_valid_q;
  logic [1:0]  s0_mode_q;
  logic [15:0] s0_addr_q;
  logic [7:0]  s0_data_q;
  logic        out_valid_q;
  sbsm_pkg::xlate_res_t out_res_q;
  logic [1:0]  out_mirror_q;
  logic [4:0]  prg_bank_count_q;
  logic        chr_is_ram_q;

  logic        in_accept;
  logic        advance;
  logic        reg_wr;
  sbsm_pkg::bank_state_t bank_state;
  sbsm_pkg::xlate_res_t  xres;
  logic [1:0]  mirror_next;

  assign advance       = s0_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s0_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign reg_wr        = advance && (s0_mode_q == sbsm_pkg::ModeRegWrite);
  assign cfg_ready_o   = 1'b1;

  sbsm_loader u_loader (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (reg_wr),
    .bus_address_i (s0_addr_q),
    .write_data_i  (s0_data_q),
    .state_o       (bank_state),
    .mirror_next_o (mirror_next)
  );

  sbsm_xlate #(
    .PRG_ADDR_BITS (PRG_ADDR_BITS)
  ) u_xlate (
    .mode_i           (s0_mode_q),
    .bus_address_i    (s0_addr_q),
    .state_i          (bank_state),
    .prg_bank_count_i (prg_bank_count_q),
    .chr_is_ram_i     (chr_is_ram_q),
    .res_o            (xres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      prg_bank_count_q <= 5'd16;
      chr_is_ram_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        s0_valid_q <= 1'b1;
      end else if (advance) begin
        s0_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sbsm_pkg::CfgPrgBankCount: prg_bank_count_q <= cfg_data_i;
          sbsm_pkg::CfgChrIsRam:     chr_is_ram_q     <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_mode_q <= s_axis_tuser;
      s0_addr_q <= s_axis_tdata[15:0];
      s0_data_q <= s_axis_tdata[23:16];
    end
    if (advance) begin
      out_res_q    <= xres;
      out_mirror_q <= mirror_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.target;
  assign m_axis_tdata  = {3'd0, out_mirror_q, out_res_q.mem_write, out_res_q.phys_addr};

`ifndef ASSERT_OFF
  a_wr_is_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tuser == sbsm_pkg::TargetChrRam))
    else $error("memory write without pattern RAM target");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline full");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item lost");
`endif

endmodule
